FILE: rtl/mhd_pkg.sv
// ----------------------------------------------------------------------------
// mhd_pkg
// Shared constants, codes and result type for the magic header deframer.
// ----------------------------------------------------------------------------
package mhd_pkg;

  localparam int BYTE_W    = 8;
  localparam int WIN_LEN   = 8;
  localparam int FILL_W    = 4;
  localparam int HDR_LEN   = 9;
  localparam int NUM_TYPES = 8;
  localparam int SIZE_W    = 32;
  localparam int TYPE_W    = 3;
  localparam int TDATA_W   = 48;

  localparam logic [BYTE_W:0] TYPE_LIMIT = (BYTE_W + 1)'(NUM_TYPES);

  localparam logic [BYTE_W-1:0] MAGIC0 = 8'h6F;  // 'o'
  localparam logic [BYTE_W-1:0] MAGIC1 = 8'h62;  // 'b'
  localparam logic [BYTE_W-1:0] MAGIC2 = 8'h75;  // 'u'
  localparam logic [BYTE_W-1:0] MAGIC3 = 8'h73;  // 's'

  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [TYPE_W-1:0]   pkt_type;
    logic [SIZE_W-1:0]   pkt_size;
    logic [BYTE_W-1:0]   data_byte;
    logic                last;
  } result_t;

endpackage

FILE: rtl/magic_header_packet_deframer.sv
// ----------------------------------------------------------------------------
// magic_header_packet_deframer
// Byte stream frame sync: hunts for a magic header, then passes the payload.
// ----------------------------------------------------------------------------
// Input words carry one stream byte in s_tdata; s_tuser high is a restart that
// empties the search window and drops any packet in progress.
// While hunting, each byte shifts into a row of eight byte cells; once the row
// is full, the row plus the new byte is checked for the 'o','b','u','s' magic,
// a big-endian 32-bit size and a type byte below the type count.
// A match gives a header word (m_tuser low) with type and size; the following
// size-9 bytes come out as payload words (m_tuser high), the final one with
// m_tlast. A size of 9 or less gives m_tlast on the header word itself.
// One input word is taken every cycle while s_tready is high; each result is
// registered in the output stage before it appears on m_tvalid. The rate is
// set by the combinational window compare and the 32-bit payload down counter.
// A two-entry output stage takes one more result word while m_tready is
// low; with both entries full, s_tready drops until a word is taken.
// Reset empties the window and the output stage and returns to hunting.
// ----------------------------------------------------------------------------
module magic_header_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [mhd_pkg::TDATA_W-1:0] m_tdata,  // pkt_type[2:0], pkt_size[34:3],
                                                // data_byte[42:35], pad
  output logic        m_tuser,   // kind
  output logic        m_tlast    // last
);

  logic [mhd_pkg::BYTE_W-1:0] win [mhd_pkg::WIN_LEN];
  logic [mhd_pkg::FILL_W-1:0] fill;
  logic                       in_payload;
  logic [mhd_pkg::SIZE_W-1:0] bytes_remaining;

  logic                       accept;
  logic                       is_data;
  logic                       full;
  logic                       match;
  logic                       shift_en;
  logic [mhd_pkg::SIZE_W-1:0] hdr_size;
  logic                       push;
  mhd_pkg::result_t           res;
  mhd_pkg::result_t           out_res;

  assign accept  = s_tvalid && s_tready;
  assign is_data = (s_tuser == mhd_pkg::OP_DATA);
  assign full    = (fill == mhd_pkg::FILL_W'(mhd_pkg::WIN_LEN));

  assign hdr_size = {win[4], win[5], win[6], win[7]};
  assign match = full && (win[0] == mhd_pkg::MAGIC0) && (win[1] == mhd_pkg::MAGIC1) &&
                 (win[2] == mhd_pkg::MAGIC2) && (win[3] == mhd_pkg::MAGIC3) &&
                 ({1'b0, s_tdata} < mhd_pkg::TYPE_LIMIT);

  assign shift_en = accept && is_data && !in_payload && !match;

  genvar gi;
  generate
    for (gi = 0; gi < mhd_pkg::WIN_LEN; gi++) begin : g_cell
      if (gi == mhd_pkg::WIN_LEN - 1) begin : g_tail
        mhd_cell u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .din      (s_tdata),
          .dout     (win[gi])
        );
      end else begin : g_body
        mhd_cell u_cell (
          .clk      (clk),
          .shift_en (shift_en),
          .din      (win[gi+1]),
          .dout     (win[gi])
        );
      end
    end
  endgenerate

  always_comb begin
    res  = '0;
    push = 1'b0;
    if (accept && is_data) begin
      if (in_payload) begin
        push          = 1'b1;
        res.kind      = mhd_pkg::KIND_PAYLOAD;
        res.data_byte = s_tdata;
        res.last      = (bytes_remaining == mhd_pkg::SIZE_W'(1));
      end else if (match) begin
        push         = 1'b1;
        res.kind     = mhd_pkg::KIND_HEADER;
        res.pkt_type = s_tdata[mhd_pkg::TYPE_W-1:0];
        res.pkt_size = hdr_size;
        res.last     = (hdr_size <= mhd_pkg::SIZE_W'(mhd_pkg::HDR_LEN));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill            <= '0;
      in_payload      <= 1'b0;
      bytes_remaining <= '0;
    end else if (accept) begin
      if (!is_data) begin
        fill            <= '0;
        in_payload      <= 1'b0;
        bytes_remaining <= '0;
      end else if (in_payload) begin
        bytes_remaining <= bytes_remaining - mhd_pkg::SIZE_W'(1);
        if (bytes_remaining == mhd_pkg::SIZE_W'(1)) begin
          in_payload <= 1'b0;
          fill       <= '0;
        end
      end else if (match) begin
        fill <= '0;
        if (hdr_size > mhd_pkg::SIZE_W'(mhd_pkg::HDR_LEN)) begin
          in_payload      <= 1'b1;
          bytes_remaining <= hdr_size - mhd_pkg::SIZE_W'(mhd_pkg::HDR_LEN);
        end else begin
          bytes_remaining <= '0;
        end
      end else if (!full) begin
        fill <= fill + mhd_pkg::FILL_W'(1);
      end
    end
  end

  mhd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (res),
    .ready     (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .dout      (out_res)
  );

  assign m_tdata = {5'd0, out_res.data_byte, out_res.pkt_size, out_res.pkt_type};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (bytes_remaining != '0))
    else $error("payload mode with zero count");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= mhd_pkg::FILL_W'(mhd_pkg::WIN_LEN))
    else $error("window fill beyond window length");

  a_header_opens: assert property (@(posedge clk) disable iff (rst)
    (push && res.kind == mhd_pkg::KIND_HEADER && !res.last) |=> in_payload)
    else $error("header without last did not open payload");

  a_payload_closes: assert property (@(posedge clk) disable iff (rst)
    (push && res.kind == mhd_pkg::KIND_PAYLOAD && res.last) |=>
      (!in_payload && fill == '0))
    else $error("last payload byte did not return to hunting");

endmodule

FILE: rtl/mhd_cell.sv
// ----------------------------------------------------------------------------
// mhd_cell
// One byte of the header search window; loads its neighbor's byte (the input byte at the tail) on shift.
// ----------------------------------------------------------------------------
module mhd_cell (
  input  logic                      clk,
  input  logic                      shift_en,
  input  logic [mhd_pkg::BYTE_W-1:0] din,
  output logic [mhd_pkg::BYTE_W-1:0] dout
);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      dout <= din;
    end
  end

endmodule

FILE: rtl/mhd_skid.sv
// ----------------------------------------------------------------------------
// mhd_skid
// Two-entry output register with skid stage for result words.
// ----------------------------------------------------------------------------
module mhd_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mhd_pkg::result_t din,
  output logic             ready,
  output logic             out_valid,
  input  logic             out_ready,
  output mhd_pkg::result_t dout
);

  logic             skid_valid;
  mhd_pkg::result_t skid;
  logic             pop;

  assign pop   = out_valid && out_ready;
  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        dout <= skid;
        if (push) begin
          skid <= din;
        end else begin
          skid_valid <= 1'b0;
        end
      end else if (push) begin
        dout <= din;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        dout      <= din;
        out_valid <= 1'b1;
      end else begin
        skid       <= din;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule
